// ===== hw/rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_PURGE      = 3'd4,
		ACT_CLEAR      = 3'd5,
		ACT_EMIT_FIRST = 3'd6,
		ACT_EMIT_LAST  = 3'd7
	} act_t;

	typedef struct packed {
		logic shl;
		logic shr;
		logic wr;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/bdq_cell.sv =====
`timescale 1ns / 1ps

module bdq_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  bdq_pkg::cell_ctl_t  ctl,
	input  logic [IW-1:0]       wr_idx,
	input  logic signed [31:0]  wr_data,
	input  logic signed [31:0]  left,
	input  logic signed [31:0]  right,
	output logic signed [31:0]  q
);
	import bdq_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr && wr_idx == MY_IDX) begin
			data_q <= wr_data;
		end else if (ctl.shl) begin
			data_q <= right;
		end else if (ctl.shr) begin
			data_q <= left;
		end
	end

	assign q = data_q;

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
`timescale 1ns / 1ps

module bdq_ctrl #(
	parameter int CAPACITY = 64,
	parameter int IW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          action,
	input  logic signed [31:0]  value,
	input  logic [6:0]          count,
	input  logic signed [31:0]  head,
	output bdq_pkg::cell_ctl_t  ctl,
	output logic [IW-1:0]       wr_idx,
	output logic signed [31:0]  wr_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  item_value,
	output logic                has_value,
	output logic                store_empty,
	output logic                rejected,
	output logic                last_of_run
);
	import bdq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RESULT = 3'b010,
		ST_WALK   = 3'b100
	} state_t;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      s_q;
	logic [CW-1:0]      e_q;
	logic               purge_q;
	logic               rej_q;
	logic signed [31:0] val_q;

	logic               out_valid_q;
	logic signed [31:0] item_value_q;
	logic               has_value_q;
	logic               store_empty_q;
	logic               rejected_q;
	logic               last_q;

	logic               accept;
	logic               out_free;
	logic               full;
	logic [CW-1:0]      n_emit;
	logic               is_out;
	logic               keep;
	logic               go;
	logic [CW-1:0]      purge_idx;
	logic [CW-1:0]      last_idx;
	logic               out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign full     = (count_q == CAP_C);
	assign n_emit   = (count < 7'(count_q)) ? CW'(count) : count_q;
	assign is_out   = !purge_q && (k_q >= s_q) && (k_q <= e_q);
	assign keep     = (head != val_q);
	assign go       = (state_q == ST_WALK) && (!is_out || out_free);
	assign purge_idx = CW'(j_q + count_q - k_q - ONE_C);
	assign last_idx = CW'(count_q - ONE_C);
	assign out_load = ((state_q == ST_RESULT) && out_free) || (go && is_out);

	always_comb begin
		ctl     = '0;
		wr_idx  = count_q[IW-1:0];
		wr_data = value;
		if (accept) begin
			case (action)
				ACT_PUSH_FRONT: ctl.shr = !full;
				ACT_PUSH_BACK:  ctl.wr  = !full;
				ACT_POP_FRONT:  ctl.shl = (count_q != '0);
				default: ;
			endcase
		end else if (go) begin
			ctl.shl = 1'b1;
			ctl.wr  = purge_q ? keep : 1'b1;
			wr_idx  = purge_q ? purge_idx[IW-1:0] : last_idx[IW-1:0];
			wr_data = head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			j_q         <= '0;
			s_q         <= '0;
			e_q         <= '0;
			purge_q     <= 1'b0;
			rej_q       <= 1'b0;
			val_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						j_q <= '0;
						case (action) inside
							ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
								if (full) begin
									rej_q   <= 1'b1;
									state_q <= ST_RESULT;
								end else begin
									count_q <= count_q + ONE_C;
								end
							end
							ACT_POP_FRONT, ACT_POP_BACK: begin
								if (count_q != '0) begin
									count_q <= count_q - ONE_C;
								end
							end
							ACT_PURGE: begin
								purge_q <= 1'b1;
								val_q   <= value;
								if (count_q != '0) begin
									state_q <= ST_WALK;
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
							end
							default: begin
								purge_q <= 1'b0;
								if (count_q == '0) begin
									rej_q   <= 1'b0;
									state_q <= ST_RESULT;
								end else if (n_emit != '0) begin
									s_q     <= (action == ACT_EMIT_FIRST) ? '0
										: CW'(count_q - n_emit);
									e_q     <= (action == ACT_EMIT_FIRST)
										? CW'(n_emit - ONE_C) : last_idx;
									state_q <= ST_WALK;
								end
							end
						endcase
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (go) begin
						if (purge_q && keep) begin
							j_q <= j_q + ONE_C;
						end
						k_q <= k_q + ONE_C;
						if (k_q == last_idx) begin
							if (purge_q) begin
								count_q <= keep ? CW'(j_q + ONE_C) : j_q;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			item_value_q  <= '0;
			has_value_q   <= 1'b0;
			store_empty_q <= !rej_q;
			rejected_q    <= rej_q;
			last_q        <= 1'b1;
		end else if (go && is_out) begin
			item_value_q  <= head;
			has_value_q   <= 1'b1;
			store_empty_q <= 1'b0;
			rejected_q    <= 1'b0;
			last_q        <= (k_q == e_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign item_value  = item_value_q;
	assign has_value   = has_value_q;
	assign store_empty = store_empty_q;
	assign rejected    = rejected_q;
	assign last_of_run = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("element count above capacity");

	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> k_q < count_q)
		else $error("walk index past live elements");

	a_shift_dir: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.shl && ctl.shr))
		else $error("chain shifted both ways");

	a_beat_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && has_value_q |-> !store_empty_q && !rejected_q)
		else $error("element beat carries a status flag");

endmodule

// ===== hw/rtl/bounded_deque_with_value_purge_core.sv =====
`timescale 1ns / 1ps

// bounded deque of signed 32-bit values with value purge
// input channel: in_valid / in_stall with action, value, count
// output channel: out_valid / out_stall with item_value, has_value,
//   store_empty, rejected, last_of_run; last_of_run marks the final beat
//   of a command
// storage is a chain of CAPACITY cells, cell 0 holds the front element
// push, pop and clear give no beat unless a push is rejected
// a rejected push or an emit on an empty store gives one status beat,
//   loaded from ST_RESULT once the output register is free
// purge and emit walk the chain one element per cycle while no emitted
//   element is held by out_stall, rotating the live elements once around;
//   purge drops those equal to value, and in_stall stays high meanwhile
// emitted elements leave one per cycle while out_stall is low, each valid in the cycle after its walk step
// when out_stall is high the walk pauses on an element to be emitted;
//   an idle block still takes a command while a beat waits
// reset empties the store; cell contents are not cleared

module bounded_deque_with_value_purge_core #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] value,
	input  logic [6:0]         count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] item_value,
	output logic               has_value,
	output logic               store_empty,
	output logic               rejected,
	output logic               last_of_run
);
	import bdq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	cell_ctl_t          ctl;
	logic [IW-1:0]      wr_idx;
	logic signed [31:0] wr_data;
	logic signed [31:0] cell_q [CAPACITY];

	bdq_ctrl #(
		.CAPACITY (CAPACITY),
		.IW       (IW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.value       (value),
		.count       (count),
		.head        (cell_q[0]),
		.ctl         (ctl),
		.wr_idx      (wr_idx),
		.wr_data     (wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.item_value  (item_value),
		.has_value   (has_value),
		.store_empty (store_empty),
		.rejected    (rejected),
		.last_of_run (last_of_run)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = wr_data;
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end

		bdq_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_idx  (wr_idx),
			.wr_data (wr_data),
			.left    (left_d),
			.right   (right_d),
			.q       (cell_q[i])
		);
	end

endmodule
